>>> design/chs_pkg.sv
// chs_pkg: shared types and constants for the chained hash set
// no dependencies
package chs_pkg;

  localparam int unsigned BUCKETS_DEF = 256;
  localparam int unsigned NODES_DEF   = 1024;
  localparam int unsigned KEY_W       = 31;
  localparam int unsigned OP_W        = 2;
  localparam int unsigned CFG_W       = 9;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned CNT_W       = 11;

  // operation codes
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISS   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NO_BKT = 2'd3;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [CNT_W-1:0]    stored_keys;
  } result_t;

endpackage

>>> design/chs_ram.sv
// chs_ram: generic single-write, single-read ram with registered read
// no dependencies
module chs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> design/chs_front.sv
// chs_front: accepts requests and computes the bucket, 4 key bits a cycle
// depends on chs_pkg
module chs_front #(
  parameter int unsigned BUCKETS = chs_pkg::BUCKETS_DEF,
  parameter int unsigned ITEM_W  = 40
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [chs_pkg::CFG_W-1:0]   num_buckets,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [chs_pkg::OP_W-1:0]    in_op,
  input  logic [chs_pkg::KEY_W-1:0]   in_key,
  output logic                        push,
  output logic [ITEM_W-1:0]           push_item,
  input  logic                        q_full
);
  localparam int unsigned RW = $clog2(BUCKETS + 1);
  localparam int unsigned BW = BUCKETS > 1 ? $clog2(BUCKETS) : 1;

  logic                        busy_r, busy_nxt;
  logic [2:0]                  iter_r, iter_nxt;
  logic                        done_r, done_nxt;
  logic [31:0]                 sh_r, sh_nxt;
  logic [RW-1:0]               rem_r, rem_nxt;
  logic [RW-1:0]               div_r;
  logic                        nbz_r;
  logic [chs_pkg::OP_W-1:0]    op_r;
  logic [chs_pkg::KEY_W-1:0]   key_r;
  logic [RW-1:0]               nb_eff;
  logic [RW:0]                 t;
  logic [RW-1:0]               r;
  logic [31:0]                 s;

  assign nb_eff   = (32'(num_buckets) > BUCKETS) ? RW'(BUCKETS) : RW'(num_buckets);
  assign in_ready = !busy_r;
  assign push     = busy_r && done_r && !q_full;
  assign push_item = {op_r, key_r, nbz_r, rem_r[BW-1:0]};

  // restoring remainder, four bits per cycle
  always_comb begin
    r = rem_r;
    s = sh_r;
    t = '0;
    for (int i = 0; i < 4; i++) begin
      t = {r, s[31]};
      s = {s[30:0], 1'b0};
      if (t >= {1'b0, div_r}) begin
        t = t - {1'b0, div_r};
      end
      r = t[RW-1:0];
    end
    busy_nxt = busy_r;
    iter_nxt = iter_r;
    done_nxt = done_r;
    sh_nxt   = sh_r;
    rem_nxt  = rem_r;
    if (!busy_r) begin
      if (in_valid) begin
        busy_nxt = 1'b1;
        iter_nxt = '0;
        done_nxt = 1'b0;
        sh_nxt   = {1'b0, in_key};
        rem_nxt  = '0;
      end
    end else if (!done_r) begin
      sh_nxt   = s;
      rem_nxt  = r;
      iter_nxt = iter_r + 3'd1;
      if (iter_r == 3'd7) begin
        done_nxt = 1'b1;
      end
    end else if (push) begin
      busy_nxt = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      iter_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      iter_r <= iter_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    sh_r  <= sh_nxt;
    rem_r <= rem_nxt;
    if (!busy_r && in_valid) begin
      op_r  <= in_op;
      key_r <= in_key;
      div_r <= nb_eff;
      nbz_r <= (nb_eff == '0);
    end
  end
endmodule

>>> design/chs_fifo.sv
// chs_fifo: two-entry queue between front and back
// no dependencies
module chs_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] pop_data
);
  logic [WIDTH-1:0] slot_r [2];
  logic             wp_r, rp_r;
  logic [1:0]       cnt_r;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign pop_data  = slot_r[rp_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop)  rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= push_data;
    end
  end
endmodule

>>> design/chs_back.sv
// chs_back: chain walker and table updater, holds the output register
// depends on chs_pkg and chs_ram
module chs_back #(
  parameter int unsigned BUCKETS = chs_pkg::BUCKETS_DEF,
  parameter int unsigned NODES   = chs_pkg::NODES_DEF,
  parameter int unsigned ITEM_W  = 40
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  logic [ITEM_W-1:0]   q_item,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output chs_pkg::result_t    out_res
);
  localparam int unsigned BW = BUCKETS > 1 ? $clog2(BUCKETS) : 1;
  localparam int unsigned NW = NODES > 1 ? $clog2(NODES) : 1;
  localparam int unsigned LW = NW + 1;
  localparam int unsigned CW = chs_pkg::CNT_W;
  localparam logic [LW-1:0] NIL = LW'(NODES);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_HEAD = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_CMP  = 3'd3;
  localparam logic [2:0] S_POP  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]                  state_r, state_nxt;
  logic [chs_pkg::OP_W-1:0]    op_r;
  logic [chs_pkg::KEY_W-1:0]   key_r;
  logic [BW-1:0]               bkt_r;
  logic [LW-1:0]               cur_r, cur_nxt, prev_r, prev_nxt, head_r, head_nxt;
  logic [BUCKETS-1:0]          hvalid_r, hvalid_nxt;
  logic [LW-1:0]               fcnt_r, fcnt_nxt, fresh_r, fresh_nxt;
  logic [chs_pkg::CNT_W-1:0]   count_r, count_nxt;
  logic [chs_pkg::STATUS_W-1:0] status_r, status_nxt;
  logic                        out_valid_r;
  chs_pkg::result_t            out_res_r;

  logic [chs_pkg::OP_W-1:0]    q_op;
  logic [chs_pkg::KEY_W-1:0]   q_key;
  logic                        q_nbz;
  logic [BW-1:0]               q_bkt;

  logic               h_we, k_we, l_we, f_we;
  logic [BW-1:0]      h_waddr;
  logic [LW-1:0]      h_wdata, h_rdata, l_wdata, l_rdata;
  logic [NW-1:0]      l_waddr, k_waddr, f_waddr, f_wdata, f_rdata, node_n;
  logic [chs_pkg::KEY_W-1:0] k_rdata;
  logic               do_ins;

  assign {q_op, q_key, q_nbz, q_bkt} = q_item;
  assign q_pop     = (state_r == S_IDLE) && q_valid;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  chs_ram #(.WIDTH(LW), .DEPTH(BUCKETS)) u_heads (
    .clk, .we(h_we), .waddr(h_waddr), .wdata(h_wdata), .raddr(q_bkt), .rdata(h_rdata)
  );
  chs_ram #(.WIDTH(chs_pkg::KEY_W), .DEPTH(NODES)) u_keys (
    .clk, .we(k_we), .waddr(k_waddr), .wdata(key_r), .raddr(cur_r[NW-1:0]),
    .rdata(k_rdata)
  );
  chs_ram #(.WIDTH(LW), .DEPTH(NODES)) u_links (
    .clk, .we(l_we), .waddr(l_waddr), .wdata(l_wdata), .raddr(cur_r[NW-1:0]),
    .rdata(l_rdata)
  );
  chs_ram #(.WIDTH(NW), .DEPTH(NODES)) u_free (
    .clk, .we(f_we), .waddr(f_waddr), .wdata(f_wdata), .raddr(NW'(fcnt_r - LW'(1))),
    .rdata(f_rdata)
  );

  // sequencer: head read, chain walk, update
  always_comb begin
    state_nxt  = state_r;
    cur_nxt    = cur_r;
    prev_nxt   = prev_r;
    head_nxt   = head_r;
    hvalid_nxt = hvalid_r;
    fcnt_nxt   = fcnt_r;
    fresh_nxt  = fresh_r;
    count_nxt  = count_r;
    status_nxt = status_r;
    h_we = 1'b0; k_we = 1'b0; l_we = 1'b0; f_we = 1'b0;
    h_waddr = bkt_r;
    h_wdata = l_rdata;
    l_waddr = prev_r[NW-1:0];
    l_wdata = l_rdata;
    f_waddr = fcnt_r[NW-1:0];
    f_wdata = cur_r[NW-1:0];
    node_n  = fresh_r[NW-1:0];
    do_ins  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          if (q_nbz) begin
            status_nxt = chs_pkg::ST_NO_BKT;
            state_nxt  = S_OUT;
          end else if (q_op != chs_pkg::OP_INSERT && q_op != chs_pkg::OP_SEARCH &&
                       q_op != chs_pkg::OP_DELETE) begin
            status_nxt = chs_pkg::ST_MISS;
            state_nxt  = S_OUT;
          end else begin
            state_nxt = S_HEAD;
          end
        end
      end
      S_HEAD: begin
        cur_nxt   = hvalid_r[bkt_r] ? h_rdata : NIL;
        head_nxt  = hvalid_r[bkt_r] ? h_rdata : NIL;
        prev_nxt  = NIL;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (cur_r == NIL) begin
          state_nxt  = S_OUT;
          status_nxt = chs_pkg::ST_MISS;
          if (op_r == chs_pkg::OP_INSERT) begin
            if (fcnt_r == '0 && fresh_r == NIL) begin
              status_nxt = chs_pkg::ST_FULL;
            end else if (fcnt_r != '0) begin
              state_nxt = S_POP;
            end else begin
              fresh_nxt = fresh_r + LW'(1);
              do_ins    = 1'b1;
            end
          end
        end else begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        if (k_rdata == key_r) begin
          state_nxt  = S_OUT;
          status_nxt = (op_r == chs_pkg::OP_INSERT) ? chs_pkg::ST_MISS : chs_pkg::ST_OK;
          if (op_r == chs_pkg::OP_DELETE) begin
            // unlink: head moves on, or the previous node skips this one
            if (prev_r == NIL) begin
              h_we = 1'b1;
            end else begin
              l_we = 1'b1;
            end
            f_we     = 1'b1;
            fcnt_nxt = fcnt_r + LW'(1);
            if (count_r != '0) count_nxt = count_r - CW'(1);
          end
        end else begin
          prev_nxt  = cur_r;
          cur_nxt   = l_rdata;
          state_nxt = S_CHK;
        end
      end
      S_POP: begin
        node_n    = f_rdata;
        fcnt_nxt  = fcnt_r - LW'(1);
        do_ins    = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    // insert at the front of the chain
    if (do_ins) begin
      k_we    = 1'b1;
      l_we    = 1'b1;
      h_we    = 1'b1;
      l_waddr = node_n;
      l_wdata = head_r;
      h_wdata = {1'b0, node_n};
      hvalid_nxt[bkt_r] = 1'b1;
      count_nxt  = count_r + CW'(1);
      status_nxt = chs_pkg::ST_OK;
    end
  end
  assign k_waddr = node_n;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      hvalid_r    <= '0;
      fcnt_r      <= '0;
      fresh_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      hvalid_r <= hvalid_nxt;
      fcnt_r   <= fcnt_nxt;
      fresh_r  <= fresh_nxt;
      count_r  <= count_nxt;
      if (state_r == S_OUT && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    cur_r    <= cur_nxt;
    prev_r   <= prev_nxt;
    head_r   <= head_nxt;
    status_r <= status_nxt;
    if (q_pop) begin
      op_r  <= q_op;
      key_r <= q_key;
      bkt_r <= q_bkt;
    end
    if (state_r == S_OUT && (!out_valid_r || out_ready)) begin
      out_res_r.status      <= status_r;
      out_res_r.stored_keys <= count_r;
    end
  end
endmodule

>>> design/chained_hash_set.sv
// chained_hash_set: top level of the chained hash set
// depends on chs_pkg, chs_front, chs_fifo, chs_back
//
// Usage: requests enter on the in_ stream (op, key); each gives exactly one
// transaction on the out_ stream (status, stored_keys). cfg_wr_en with
// cfg_wr_data sets the bucket count; write it only while the block is idle.
// The front computes key modulo the bucket count at 4 bits per cycle,
// then hands the request through a two-entry queue to the back.
// The back reads the bucket head, walks the chain node by node, and
// updates the tables; it then loads the output register. The front
// computes the next bucket while the back walks, so throughput is set by
// the slower of the front (accept, divider steps, hand-off) and the
// back's chain walk.
// Reset empties every bucket and the node pool; no clearing pass is needed.
// A stalled receiver holds the output register; the queue then fills and
// in_tready drops.
module chained_hash_set #(
  parameter int unsigned BUCKETS = chs_pkg::BUCKETS_DEF,
  parameter int unsigned NODES   = chs_pkg::NODES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [8:0]  cfg_wr_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // op[1:0], key[32:2], zero fill
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // status[1:0], stored_keys[12:2], zero fill
);
  localparam int unsigned BW     = BUCKETS > 1 ? $clog2(BUCKETS) : 1;
  localparam int unsigned ITEM_W = chs_pkg::OP_W + chs_pkg::KEY_W + 1 + BW;

  logic [chs_pkg::CFG_W-1:0] num_buckets_r;
  logic              push, q_full, q_valid, q_pop;
  logic [ITEM_W-1:0] push_item, q_item;
  chs_pkg::result_t  res;

  // bucket count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_buckets_r <= '0;
    end else if (cfg_wr_en) begin
      num_buckets_r <= cfg_wr_data;
    end
  end

  chs_front #(.BUCKETS(BUCKETS), .ITEM_W(ITEM_W)) u_front (
    .clk, .rst_n, .num_buckets(num_buckets_r),
    .in_valid(in_tvalid), .in_ready(in_tready),
    .in_op(in_tdata[1:0]), .in_key(in_tdata[32:2]),
    .push, .push_item, .q_full
  );

  chs_fifo #(.WIDTH(ITEM_W)) u_queue (
    .clk, .rst_n, .push, .push_data(push_item), .full(q_full),
    .pop(q_pop), .not_empty(q_valid), .pop_data(q_item)
  );

  chs_back #(.BUCKETS(BUCKETS), .NODES(NODES), .ITEM_W(ITEM_W)) u_back (
    .clk, .rst_n, .q_valid, .q_item, .q_pop,
    .out_valid(out_tvalid), .out_ready(out_tready), .out_res(res)
  );

  assign out_tdata = {3'b000, res.stored_keys, res.status};
endmodule

>>> design/chs_checker.sv
// chs_checker: port-level checks for chained_hash_set, bound to the top level
// depends on chained_hash_set
module chs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);
  logic [3:0] pend_r;

  // transactions accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + 4'(in_tvalid && in_tready) - 4'(out_tvalid && out_tready);
    end
  end

  a_no_result_unasked: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> pend_r != 4'd0) else $error("result without a request");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata)) else $error("stalled result changed");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid) else $error("result right after reset");

  // front, two queue slots, back sequencer and output register
  a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= 4'd5) else $error("too many requests in flight");
endmodule

bind chained_hash_set chs_checker u_chk (
  .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready, .out_tdata
);
